// ===== src/ssr_pkg.sv =====
// Shared types and constants for the streaming search-and-replace block.
package ssr_pkg;

  localparam int DefMaxSearchBytes  = 8;
  localparam int DefMaxReplaceBytes = 8;

  localparam int PatBytes = 8;              // bytes held by a pattern register
  localparam int PatW     = 8 * PatBytes;   // pattern register width
  localparam int LenW     = 4;              // length register width
  localparam int CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSearchPattern  = 2'd0,
    CfgSearchLength   = 2'd1,
    CfgReplacePattern = 2'd2,
    CfgReplaceLength  = 2'd3
  } cfg_reg_e;

  // Burst handed from the window logic to the output stage.
  typedef struct packed {
    logic            load;
    logic            byte_valid;
    logic [LenW-1:0] len;
  } burst_req_t;

endpackage

// ===== src/ssr_cell.sv =====
// One window cell: holds a byte, compares it with its pattern byte, shifts down.
module ssr_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 4
) (
  input  logic             clk_i,
  input  logic [CNT_W-1:0] count_i,     // window fill before this request
  input  logic [7:0]       in_byte_i,
  input  logic [7:0]       pat_byte_i,
  input  logic [7:0]       next_eff_i,  // effective byte of the cell above
  input  logic             accept_i,
  input  logic             shift_i,
  output logic [7:0]       eff_byte_o,
  output logic             eq_o
);

  logic [7:0] byte_q, byte_d;
  logic       here;

  // The incoming byte lands in the cell at the current fill position.
  assign here       = (count_i == CNT_W'(CELL_IDX));
  assign eff_byte_o = here ? in_byte_i : byte_q;
  assign eq_o       = (eff_byte_o == pat_byte_i);

  always_comb begin
    byte_d = byte_q;
    if (accept_i) begin
      if (shift_i) begin
        byte_d = next_eff_i;
      end else if (here) begin
        byte_d = in_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

// ===== src/ssr_emit.sv =====
// Output stage: holds one result burst, drains it one per cycle while ready.
module ssr_emit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ssr_pkg::burst_req_t      req_i,
  input  logic [ssr_pkg::PatW-1:0] bytes_i,
  output logic                     free_o,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,  // out_byte
  output logic                     m_axis_tuser,  // byte_valid
  output logic                     m_axis_tlast   // last_result
);

  logic [ssr_pkg::PatW-1:0] bytes_q, bytes_d;
  logic [ssr_pkg::LenW-1:0] rem_q, rem_d;
  logic                     bval_q, bval_d;
  logic                     pop;

  assign m_axis_tvalid = (rem_q != '0);
  assign m_axis_tdata  = bytes_q[7:0];
  assign m_axis_tuser  = bval_q;
  assign m_axis_tlast  = (rem_q == ssr_pkg::LenW'(1));
  assign pop           = m_axis_tvalid && m_axis_tready;
  // Free in this cycle if empty or the final result goes out now.
  assign free_o        = (rem_q == '0) || (m_axis_tlast && m_axis_tready);

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    bval_d  = bval_q;
    if (pop) begin
      bytes_d = {8'h00, bytes_q[ssr_pkg::PatW-1:8]};
      rem_d   = rem_q - ssr_pkg::LenW'(1);
    end
    if (req_i.load) begin
      bytes_d = bytes_i;
      rem_d   = req_i.len;
      bval_d  = req_i.byte_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    bval_q  <= bval_d;
  end

endmodule

// ===== src/stream_search_replace.sv =====
// Streaming search and replace: top level with window cells, match logic and config.
// Replaces every leftmost, non-overlapping occurrence of the search pattern in a byte
// stream with the replacement pattern. Input bytes enter a row of window cells, one
// cell per search byte; the comparison against the pattern is made in the cycle the
// byte is taken. Results go to an output stage that sends one byte per cycle while the
// receiver is ready; a multi-result byte holds the input until its last goes out,
// others (none or one result) are taken each cycle; throughput is set by that stage.
// The last result of each input byte carries tlast; at end of text with nothing left
// to send a single result with tuser low and data zero marks the end. Writing the
// search length discards the window. Configure only while the block is idle.
module stream_search_replace #(
  parameter int MAX_SEARCH_BYTES  = ssr_pkg::DefMaxSearchBytes,
  parameter int MAX_REPLACE_BYTES = ssr_pkg::DefMaxReplaceBytes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ssr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ssr_pkg::PatW-1:0]    cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // text_byte
  input  logic                        s_axis_tlast,  // end_of_text
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // out_byte
  output logic                        m_axis_tuser,  // byte_valid
  output logic                        m_axis_tlast   // last_result
);

  localparam int WinCap = (MAX_SEARCH_BYTES < ssr_pkg::PatBytes) ?
                          MAX_SEARCH_BYTES : ssr_pkg::PatBytes;
  localparam int RepCap = (MAX_REPLACE_BYTES < ssr_pkg::PatBytes) ?
                          MAX_REPLACE_BYTES : ssr_pkg::PatBytes;
  localparam int CntW   = (WinCap < 2) ? 1 : $clog2(WinCap + 1);
  localparam int LenW   = ssr_pkg::LenW;

  logic [ssr_pkg::PatW-1:0] spat_q, rpat_q;
  logic [LenW-1:0]          slen_q, rlen_q;
  logic [CntW-1:0]          count_q, count_d;

  logic [LenW-1:0]          slen_eff, rlen_eff, cnt_ext, len;
  logic [7:0]               eff [WinCap];
  logic [WinCap-1:0]        eq;
  logic                     accept, full, match, shift, free;
  logic [ssr_pkg::PatW-1:0] win_bytes, burst_bytes;
  ssr_pkg::burst_req_t      req;

  // Effective lengths: zero search acts as one, both saturate at their caps.
  always_comb begin
    slen_eff = slen_q;
    if (slen_q == '0) begin
      slen_eff = LenW'(1);
    end else if (slen_q > LenW'(WinCap)) begin
      slen_eff = LenW'(WinCap);
    end
    rlen_eff = (rlen_q > LenW'(RepCap)) ? LenW'(RepCap) : rlen_q;
  end

  assign accept  = s_axis_tvalid && free;
  assign s_axis_tready = free;
  assign cnt_ext = LenW'(count_q);
  assign full    = ((cnt_ext + LenW'(1)) == slen_eff);
  assign shift   = full && !match;

  for (genvar i = 0; i < WinCap; i++) begin : g_cell
    logic [7:0] next_eff;
    if (i == WinCap - 1) begin : g_top
      assign next_eff = eff[i];
    end else begin : g_mid
      assign next_eff = eff[i+1];
    end
    ssr_cell #(
      .CELL_IDX (i),
      .CNT_W    (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .count_i    (count_q),
      .in_byte_i  (s_axis_tdata),
      .pat_byte_i (spat_q[8*i +: 8]),
      .next_eff_i (next_eff),
      .accept_i   (accept),
      .shift_i    (shift),
      .eff_byte_o (eff[i]),
      .eq_o       (eq[i])
    );
  end

  always_comb begin
    match     = 1'b1;
    win_bytes = '0;
    for (int i = 0; i < WinCap; i++) begin
      if (LenW'(i) < slen_eff) begin
        match = match && eq[i];
      end
      win_bytes[8*i +: 8] = eff[i];
    end
  end

  // Burst length and source for this request.
  always_comb begin
    req.byte_valid = 1'b1;
    burst_bytes    = win_bytes;
    if (full && match) begin
      len         = rlen_eff;
      burst_bytes = rpat_q;
    end else if (full) begin
      len = s_axis_tlast ? slen_eff : LenW'(1);
    end else begin
      len = s_axis_tlast ? (cnt_ext + LenW'(1)) : '0;
    end
    if (s_axis_tlast && (len == '0)) begin
      len            = LenW'(1);
      req.byte_valid = 1'b0;
      burst_bytes    = '0;
    end
    req.len  = len;
    req.load = accept && (len != '0);
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (s_axis_tlast || (full && match)) begin
        count_d = '0;
      end else if (!full) begin
        count_d = count_q + CntW'(1);
      end
    end
    if (cfg_we_i && (ssr_pkg::cfg_reg_e'(cfg_idx_i) == ssr_pkg::CfgSearchLength)) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spat_q  <= '0;
      slen_q  <= LenW'(1);
      rpat_q  <= '0;
      rlen_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        case (ssr_pkg::cfg_reg_e'(cfg_idx_i))
          ssr_pkg::CfgSearchPattern:  spat_q <= cfg_data_i;
          ssr_pkg::CfgSearchLength:   slen_q <= cfg_data_i[LenW-1:0];
          ssr_pkg::CfgReplacePattern: rpat_q <= cfg_data_i;
          ssr_pkg::CfgReplaceLength:  rlen_q <= cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
    end
  end

  ssr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .bytes_i       (burst_bytes),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
